### rtl/core/pafk_pkg.sv
// pafk_pkg: shared constants and types for the planar arm forward kinematics block
// no dependencies

package pafk_pkg;

    localparam int MAX_LINKS_DEF  = 4;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int LINK_FIELDS    = 4;
    localparam int IN_ANGLE_W     = 16;
    localparam int LEN_W          = 16;
    localparam int BASE_W         = 16;
    localparam int CNT_W          = 3;
    localparam int POS_W          = 20;
    localparam int ACC_W          = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEN0       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEN3       = 3'd6;

    localparam logic [31:0] Q30_ONE = 32'd1073741824;
    localparam logic [31:0] SIN_C1  = 32'd1686629713;
    localparam logic [31:0] SIN_C3  = 32'd693598668;
    localparam logic [31:0] SIN_C5  = 32'd85569306;
    localparam logic [31:0] SIN_C7  = 32'd5026995;
    localparam logic [31:0] SIN_C9  = 32'd172272;

    // token passed from cell to cell
    typedef struct packed {
        logic                   valid;
        logic [CNT_W-1:0]       joint;
        logic                   last;
        logic signed [ACC_W-1:0] px;
        logic signed [ACC_W-1:0] py;
    } t_tok;

endpackage

### rtl/core/pafk_if.sv
// pafk_if: valid/ready channel interfaces for angles, positions and config
// uses pafk_pkg

interface pafk_in_if import pafk_pkg::*; ();
    logic valid;
    logic ready;
    logic [IN_ANGLE_W-1:0] angle_joint0;
    logic [IN_ANGLE_W-1:0] angle_joint1;
    logic [IN_ANGLE_W-1:0] angle_joint2;
    logic [IN_ANGLE_W-1:0] angle_joint3;
    modport source (output valid, angle_joint0, angle_joint1, angle_joint2, angle_joint3,
                    input ready);
    modport sink (input valid, angle_joint0, angle_joint1, angle_joint2, angle_joint3,
                  output ready);
endinterface

interface pafk_out_if import pafk_pkg::*; ();
    logic valid;
    logic ready;
    logic [CNT_W-1:0] joint_number;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic last_joint;
    modport source (output valid, joint_number, pos_x, pos_y, last_joint, input ready);
    modport sink (input valid, joint_number, pos_x, pos_y, last_joint, output ready);
endinterface

interface pafk_cfg_if import pafk_pkg::*; ();
    logic valid;
    logic ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/pafk_sincos.sv
// pafk_sincos: sequential sine/cosine of one angle, one multiply per cycle
// uses pafk_pkg

module pafk_sincos import pafk_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [ANGLE_BITS-1:0]   i_angle,
    output logic                    o_done,
    output logic signed [17:0]      o_sin,
    output logic signed [17:0]      o_cos
);
    // two passes (x then 1-x), each: x2, 4 horner steps, final product = 6 mults
    typedef enum logic [1:0] {S_IDLE, S_RUN} t_state;
    t_state r_state;
    logic [2:0]  r_step;
    logic        r_pass;
    logic [1:0]  r_quad;
    logic [31:0] r_x, r_xc, r_x2, r_t;
    logic [16:0] r_ps, r_pc;
    logic        r_done;

    logic [31:0] w_xs, w_ma, w_mb, w_prod;
    logic [63:0] w_full;
    logic [31:0] w_pr;
    logic [16:0] w_fin;

    assign w_xs = r_pass ? r_xc : r_x;
    always_comb begin
        w_ma = r_x2;
        w_mb = r_t;
        case (r_step)
            3'd0: begin w_ma = w_xs; w_mb = w_xs; end
            3'd5: begin w_ma = w_xs; w_mb = r_t; end
            default: begin w_ma = r_x2; w_mb = r_t; end
        endcase
    end
    assign w_full = 64'(w_ma) * 64'(w_mb) + 64'h2000_0000;
    assign w_prod = w_full[61:30];
    assign w_pr   = (w_prod + 32'h2000) >> 14;
    assign w_fin  = (w_pr > 32'd65536) ? 17'd65536 : w_pr[16:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_quad  <= i_angle[ANGLE_BITS-1 -: 2];
                        r_x     <= 32'(i_angle[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
                        r_xc    <= Q30_ONE - (32'(i_angle[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS));
                        r_step  <= 3'd0;
                        r_pass  <= 1'b0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    case (r_step)
                        3'd0: begin r_x2 <= w_prod; r_t <= SIN_C9; end
                        3'd1: r_t <= SIN_C7 - w_prod;
                        3'd2: r_t <= SIN_C5 - w_prod;
                        3'd3: r_t <= SIN_C3 - w_prod;
                        3'd4: r_t <= SIN_C1 - w_prod;
                        default: begin
                            if (r_pass) r_pc <= w_fin;
                            else r_ps <= w_fin;
                        end
                    endcase
                    if (r_step == 3'd5) begin
                        r_step <= 3'd0;
                        r_pass <= 1'b1;
                        if (r_pass) begin
                            r_state <= S_IDLE;
                            r_done  <= 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        case (r_quad)
            2'd0: begin o_sin = 18'($signed({1'b0, r_ps})); o_cos = 18'($signed({1'b0, r_pc})); end
            2'd1: begin o_sin = 18'($signed({1'b0, r_pc})); o_cos = -18'($signed({1'b0, r_ps})); end
            2'd2: begin o_sin = -18'($signed({1'b0, r_ps})); o_cos = -18'($signed({1'b0, r_pc})); end
            default: begin o_sin = -18'($signed({1'b0, r_pc})); o_cos = 18'($signed({1'b0, r_ps})); end
        endcase
    end
    assign o_done = r_done;
endmodule

### rtl/core/pafk_cell.sv
// pafk_cell: one link of the chain; adds its rotated link vector to the running position
// uses pafk_pkg, pafk_sincos

module pafk_cell import pafk_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ANGLE_BITS-1:0] i_phi,
    input  logic [LEN_W-1:0]      i_len,
    input  t_tok                  i_tok,
    output logic                  o_done,
    output t_tok                  o_tok
);
    logic        w_done;
    logic signed [17:0] w_sin, w_cos;
    logic signed [ACC_W-1:0] r_px, r_py;
    logic signed [ACC_W-1:0] w_tx, w_ty;
    logic signed [35:0] w_mx, w_my;
    logic signed [ACC_W-1:0] r_opx, r_opy;
    logic        r_done;

    pafk_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_angle(i_phi),
        .o_done(w_done), .o_sin(w_sin), .o_cos(w_cos)
    );

    // latch incoming position at start
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_px <= i_tok.px;
            r_py <= i_tok.py;
        end
    end

    assign w_mx = $signed({2'b00, i_len}) * w_cos + 36'sd32768;
    assign w_my = $signed({2'b00, i_len}) * w_sin + 36'sd32768;
    // arithmetic shift gives floor, matching round half up
    assign w_tx = ACC_W'(w_mx >>> 16);
    assign w_ty = ACC_W'(w_my >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_done;
        end
        if (w_done) begin
            r_opx <= r_px + w_tx;
            r_opy <= r_py + w_ty;
        end
    end
    assign o_tok = '{valid: 1'b1, joint: '0, last: 1'b0, px: r_opx, py: r_opy};
    assign o_done = r_done;
endmodule

### rtl/core/planar_arm_forward_kinematics.sv
// planar_arm_forward_kinematics: top level, config registers, cell chain and output sequencer
// uses pafk_pkg, pafk_if, pafk_cell
//
// Usage:
//  - i_cfg: write register index/data (0 base_x, 1 base_y, 2 link_count,
//    3..6 link lengths). Write only while idle; unknown indexes are ignored.
//  - i_in: one transfer carries four joint angles (fractions of a turn).
//  - o_out: n+1 transfers per item, joint 0 (base) to joint n, n = link
//    count clamped to 1..min(MAX_LINKS, 4); last_joint marks the end effector.
//  - Chain: every cell has its own sine/cosine unit (12 multiply steps and
//    a done register) plus a register for the new position. All
//    min(MAX_LINKS, 4) cells run in turn for every item before the first
//    result is loaded into the output register. The next input is accepted
//    once the last result is in the output register; one item is in flight
//    at a time.
//  - Results leave from an output register; a stalled receiver holds it
//    and the block waits. Reset restores base 0, 2 links, lengths 1.0.

module planar_arm_forward_kinematics import pafk_pkg::*; #(
    parameter int MAX_LINKS  = MAX_LINKS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pafk_cfg_if.sink   i_cfg,
    pafk_in_if.sink    i_in,
    pafk_out_if.source o_out
);
    localparam int NL = (MAX_LINKS < LINK_FIELDS) ? MAX_LINKS : LINK_FIELDS;

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_EMIT} t_state;

    logic signed [BASE_W-1:0] r_base_x, r_base_y;
    logic [CNT_W-1:0] r_link_count;
    logic [LEN_W-1:0] r_len [LINK_FIELDS];

    t_state r_state;
    logic [ANGLE_BITS-1:0] r_ang [NL];
    logic [ANGLE_BITS-1:0] w_phi [NL];
    logic [ANGLE_BITS-1:0] w_cell_phi [NL];
    logic [CNT_W-1:0] r_n, r_k;
    logic signed [ACC_W-1:0] r_px [NL+1];
    logic signed [ACC_W-1:0] r_py [NL+1];
    logic [CNT_W-1:0] n_cnt;
    logic r_ov;
    logic [CNT_W-1:0] r_oj;
    logic signed [POS_W-1:0] r_ox, r_oy;
    logic r_ol;

    logic [NL-1:0] w_start, w_done;
    t_tok w_tin [NL];
    t_tok w_tout [NL];

    // config
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x <= '0;
            r_base_y <= '0;
            r_link_count <= 3'd2;
            for (int i = 0; i < LINK_FIELDS; i++) r_len[i] <= 16'd256;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_BASE_X) r_base_x <= i_cfg.data;
            else if (i_cfg.index == REG_BASE_Y) r_base_y <= i_cfg.data;
            else if (i_cfg.index == REG_LINK_COUNT) r_link_count <= i_cfg.data[CNT_W-1:0];
            else if (i_cfg.index >= REG_LEN0 && i_cfg.index <= REG_LEN3)
                r_len[2'(i_cfg.index - REG_LEN0)] <= i_cfg.data;
        end
    end

    always_comb begin
        n_cnt = r_link_count;
        if (n_cnt == '0) n_cnt = 3'd1;
        if (n_cnt > CNT_W'(NL)) n_cnt = CNT_W'(NL);
    end

    // chain of cells: cell j starts when cell j-1 is done
    genvar g;
    generate
        for (g = 0; g < NL; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_start[g] = (r_state == S_IDLE) && i_in.valid;
                // first cell takes its angle straight from the input transfer
                assign w_cell_phi[g] = ANGLE_BITS'(i_in.angle_joint0);
            end else begin : g_next
                assign w_start[g] = w_done[g-1];
                assign w_cell_phi[g] = w_phi[g];
            end
            assign w_tin[g].valid = 1'b1;
            assign w_tin[g].joint = CNT_W'(g);
            assign w_tin[g].last  = 1'b0;
            assign w_tin[g].px = (g == 0) ? ACC_W'(r_base_x) : w_tout[(g == 0) ? 0 : g-1].px;
            assign w_tin[g].py = (g == 0) ? ACC_W'(r_base_y) : w_tout[(g == 0) ? 0 : g-1].py;
            pafk_cell #(.ANGLE_BITS(ANGLE_BITS)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start[g]),
                .i_phi(w_cell_phi[g]), .i_len(r_len[g]), .i_tok(w_tin[g]),
                .o_done(w_done[g]), .o_tok(w_tout[g])
            );
        end
    endgenerate

    // running angle sums, settled before each later cell starts
    always_comb begin
        for (int j = 0; j < NL; j++) begin
            w_phi[j] = (j == 0) ? r_ang[0] : ANGLE_BITS'(w_phi[(j == 0) ? 0 : j-1] + r_ang[j]);
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    function automatic logic signed [POS_W-1:0] sat(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(524287)) return POS_W'(524287);
        if (v < -ACC_W'(524288)) return -POS_W'(524288);
        return v[POS_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_ang[0] <= ANGLE_BITS'(i_in.angle_joint0);
                        if (NL > 1) r_ang[1 % NL] <= ANGLE_BITS'(i_in.angle_joint1);
                        if (NL > 2) r_ang[2 % NL] <= ANGLE_BITS'(i_in.angle_joint2);
                        if (NL > 3) r_ang[3 % NL] <= ANGLE_BITS'(i_in.angle_joint3);
                        r_n <= n_cnt;
                        r_px[0] <= ACC_W'(r_base_x);
                        r_py[0] <= ACC_W'(r_base_y);
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (w_done[NL-1]) begin
                        r_k <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov <= 1'b1;
                        r_oj <= r_k;
                        r_ox <= sat(r_px[r_k]);
                        r_oy <= sat(r_py[r_k]);
                        r_ol <= (r_k == r_n);
                        if (r_k == r_n) r_state <= S_IDLE;
                        r_k <= r_k + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_ov && o_out.ready && !(r_state == S_EMIT)) r_ov <= 1'b0;
        end
        for (int j = 0; j < NL; j++) begin
            if (w_done[j]) begin
                r_px[j+1] <= w_tout[j].px;
                r_py[j+1] <= w_tout[j].py;
            end
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.joint_number = r_oj;
    assign o_out.pos_x = r_ox;
    assign o_out.pos_y = r_oy;
    assign o_out.last_joint = r_ol;
endmodule
